// ===== rtl/core/uetb_pkg.sv =====
`default_nettype none

package uetb_pkg;

    localparam int EDGE_CAPACITY = 1024;
    localparam int VERTEX_LIMIT  = 256;

    localparam int VERT_W  = $clog2(VERTEX_LIMIT);
    localparam int IDX_W   = $clog2(EDGE_CAPACITY);
    localparam int TOTAL_W = $clog2(EDGE_CAPACITY + 1);
    localparam int USE_W   = 8;
    localparam int ENTRY_W = 2 * VERT_W + USE_W;

    localparam logic [TOTAL_W-1:0] CAP_COUNT = TOTAL_W'(EDGE_CAPACITY);
    localparam logic [USE_W-1:0]   USE_MAX   = {USE_W{1'b1}};

    localparam logic KIND_CLEAR    = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EDGE_AB,
        EDGE_BC,
        EDGE_CA
    } edge_sel_t;

    typedef struct packed {
        logic              kind;
        logic [VERT_W-1:0] vert_a;
        logic [VERT_W-1:0] vert_b;
        logic [VERT_W-1:0] vert_c;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             valid;
        logic [USE_W-1:0] uses;
    } edge_res_t;

    typedef struct packed {
        edge_res_t          ab;
        edge_res_t          bc;
        edge_res_t          ca;
        logic [TOTAL_W-1:0] total;
    } result_t;

    // one table entry: low vertex, high vertex, use count
    typedef struct packed {
        logic [VERT_W-1:0] lo;
        logic [VERT_W-1:0] hi;
        logic [USE_W-1:0]  uses;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/uetb_if.sv =====
`default_nettype none

interface uetb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [uetb_pkg::VERT_W-1:0] vert_a;
    logic [uetb_pkg::VERT_W-1:0] vert_b;
    logic [uetb_pkg::VERT_W-1:0] vert_c;

    modport source (output valid, output kind, output vert_a, output vert_b,
                    output vert_c, input ready);
    modport sink   (input valid, input kind, input vert_a, input vert_b,
                    input vert_c, output ready);
endinterface

interface uetb_out_if;
    logic                         valid;
    logic                         ready;
    logic [uetb_pkg::IDX_W-1:0]   edge_ab_index;
    logic                         edge_ab_valid;
    logic [uetb_pkg::USE_W-1:0]   edge_ab_uses;
    logic [uetb_pkg::IDX_W-1:0]   edge_bc_index;
    logic                         edge_bc_valid;
    logic [uetb_pkg::USE_W-1:0]   edge_bc_uses;
    logic [uetb_pkg::IDX_W-1:0]   edge_ca_index;
    logic                         edge_ca_valid;
    logic [uetb_pkg::USE_W-1:0]   edge_ca_uses;
    logic [uetb_pkg::TOTAL_W-1:0] edge_total;

    modport source (output valid, output edge_ab_index, output edge_ab_valid,
                    output edge_ab_uses, output edge_bc_index, output edge_bc_valid,
                    output edge_bc_uses, output edge_ca_index, output edge_ca_valid,
                    output edge_ca_uses, output edge_total, input ready);
    modport sink   (input valid, input edge_ab_index, input edge_ab_valid,
                    input edge_ab_uses, input edge_bc_index, input edge_bc_valid,
                    input edge_bc_uses, input edge_ca_index, input edge_ca_valid,
                    input edge_ca_uses, input edge_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/uetb_edge_ram.sv =====
`default_nettype none

module uetb_edge_ram (
    input  wire logic               clk,
    input  wire uetb_pkg::ram_req_t req,
    output uetb_pkg::entry_t        rdata
);

    uetb_pkg::entry_t mem [uetb_pkg::EDGE_CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/uetb_ctrl.sv =====
`default_nettype none

module uetb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire uetb_pkg::in_item_t in_item,
    output logic                    res_valid,
    input  wire logic               res_take,
    output uetb_pkg::result_t       res,
    output uetb_pkg::ram_req_t      ram_req,
    input  wire uetb_pkg::entry_t   ram_rdata
);

    uetb_pkg::state_t    state_reg, state_next;
    uetb_pkg::edge_sel_t edge_sel_reg, edge_sel_next;

    logic [uetb_pkg::VERT_W-1:0]  va_reg, va_next;
    logic [uetb_pkg::VERT_W-1:0]  vb_reg, vb_next;
    logic [uetb_pkg::VERT_W-1:0]  vc_reg, vc_next;
    logic [uetb_pkg::TOTAL_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [uetb_pkg::TOTAL_W-1:0] size_reg, size_next;
    logic [uetb_pkg::IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                         pend_reg, pend_next;
    uetb_pkg::edge_res_t          ab_reg, ab_next;
    uetb_pkg::edge_res_t          bc_reg, bc_next;
    uetb_pkg::edge_res_t          ca_reg, ca_next;

    logic [uetb_pkg::VERT_W-1:0] p, q, lo, hi;
    logic [uetb_pkg::USE_W-1:0]  bumped;
    logic                        hit, miss_end, edge_done, full;
    uetb_pkg::edge_res_t         cur_res;

    localparam logic [uetb_pkg::USE_W-1:0] USE_W_ONE = uetb_pkg::USE_W'(1);

    // endpoints of the edge under search
    always_comb
    begin
        unique case (edge_sel_reg)
            uetb_pkg::EDGE_AB: begin p = va_reg; q = vb_reg; end
            uetb_pkg::EDGE_BC: begin p = vb_reg; q = vc_reg; end
            uetb_pkg::EDGE_CA: begin p = vc_reg; q = va_reg; end
            default:           begin p = va_reg; q = vb_reg; end
        endcase
    end

    assign lo        = (p < q) ? p : q;
    assign hi        = (p < q) ? q : p;
    assign hit       = pend_reg && (ram_rdata.lo == lo) && (ram_rdata.hi == hi);
    assign miss_end  = !pend_reg && (rd_cnt_reg == size_reg);
    assign edge_done = hit || miss_end;
    assign full      = (size_reg == uetb_pkg::CAP_COUNT);
    assign bumped    = (ram_rdata.uses == uetb_pkg::USE_MAX) ? ram_rdata.uses
                                                             : ram_rdata.uses + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            uetb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_item.kind == uetb_pkg::KIND_TRIANGLE)
                                 ? uetb_pkg::ST_SEARCH : uetb_pkg::ST_FINISH;
                end
            end
            uetb_pkg::ST_SEARCH:
            begin
                if (edge_done && (edge_sel_reg == uetb_pkg::EDGE_CA))
                begin
                    state_next = uetb_pkg::ST_FINISH;
                end
            end
            uetb_pkg::ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = uetb_pkg::ST_IDLE;
                end
            end
            default: state_next = uetb_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        va_next       = va_reg;
        vb_next       = vb_reg;
        vc_next       = vc_reg;
        edge_sel_next = edge_sel_reg;
        rd_cnt_next   = rd_cnt_reg;
        size_next     = size_reg;
        cmp_idx_next  = cmp_idx_reg;
        pend_next     = pend_reg;
        ab_next       = ab_reg;
        bc_next       = bc_reg;
        ca_next       = ca_reg;
        cur_res       = '0;

        ram_req.we    = 1'b0;
        ram_req.waddr = cmp_idx_reg;
        ram_req.wdata = '{lo: lo, hi: hi, uses: bumped};
        ram_req.raddr = rd_cnt_reg[uetb_pkg::IDX_W-1:0];

        unique case (state_reg)
            uetb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    va_next       = in_item.vert_a;
                    vb_next       = in_item.vert_b;
                    vc_next       = in_item.vert_c;
                    edge_sel_next = uetb_pkg::EDGE_AB;
                    rd_cnt_next   = '0;
                    pend_next     = 1'b0;
                    if (in_item.kind == uetb_pkg::KIND_CLEAR)
                    begin
                        size_next = '0;
                        ab_next   = '0;
                        bc_next   = '0;
                        ca_next   = '0;
                    end
                end
            end
            uetb_pkg::ST_SEARCH:
            begin
                if (!edge_done && (rd_cnt_reg < size_reg))
                begin
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    cmp_idx_next = rd_cnt_reg[uetb_pkg::IDX_W-1:0];
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (hit)
                begin
                    // write back the bumped count at the matching entry
                    ram_req.we = 1'b1;
                    cur_res    = '{index: cmp_idx_reg, valid: 1'b1, uses: bumped};
                end
                else if (miss_end && !full)
                begin
                    // append at the end of the table
                    ram_req.we    = 1'b1;
                    ram_req.waddr = size_reg[uetb_pkg::IDX_W-1:0];
                    ram_req.wdata = '{lo: lo, hi: hi, uses: USE_W_ONE};
                    size_next     = size_reg + 1'b1;
                    cur_res       = '{index: size_reg[uetb_pkg::IDX_W-1:0], valid: 1'b1,
                                      uses: USE_W_ONE};
                end

                if (edge_done)
                begin
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                    unique case (edge_sel_reg)
                        uetb_pkg::EDGE_AB:
                        begin
                            ab_next       = cur_res;
                            edge_sel_next = uetb_pkg::EDGE_BC;
                        end
                        uetb_pkg::EDGE_BC:
                        begin
                            bc_next       = cur_res;
                            edge_sel_next = uetb_pkg::EDGE_CA;
                        end
                        uetb_pkg::EDGE_CA:
                        begin
                            ca_next = cur_res;
                        end
                        default: edge_sel_next = uetb_pkg::EDGE_AB;
                    endcase
                end
            end
            uetb_pkg::ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= uetb_pkg::ST_IDLE;
            edge_sel_reg <= uetb_pkg::EDGE_AB;
            rd_cnt_reg   <= '0;
            size_reg     <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            edge_sel_reg <= edge_sel_next;
            rd_cnt_reg   <= rd_cnt_next;
            size_reg     <= size_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        vc_reg      <= vc_next;
        cmp_idx_reg <= cmp_idx_next;
        ab_reg      <= ab_next;
        bc_reg      <= bc_next;
        ca_reg      <= ca_next;
    end

    assign in_ready  = (state_reg == uetb_pkg::ST_IDLE);
    assign res_valid = (state_reg == uetb_pkg::ST_FINISH);
    assign res       = '{ab: ab_reg, bc: bc_reg, ca: ca_reg, total: size_reg};

endmodule

`default_nettype wire

// ===== rtl/core/unique_edge_table_builder_core.sv =====
// flow: a clear item passes straight to the output register; a triangle item
//   first searches the table for each of its edges in turn, ab, bc, then ca
// throughput: one item at a time, set by the linear search of the edge ram,
//   one entry compared per cycle over its single read port
// reset: rst_n asynchronous, active low; empties the table and drops any result
`default_nettype none

module unique_edge_table_builder_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    uetb_in_if.sink    in_ch,
    uetb_out_if.source out_ch
);

    uetb_pkg::in_item_t in_item;
    uetb_pkg::result_t  res;
    uetb_pkg::ram_req_t ram_req;
    uetb_pkg::entry_t   ram_rdata;
    logic               res_valid;
    logic               res_take;

    // output register: holds one finished item while the next one searches
    logic              out_valid_reg, out_valid_next;
    uetb_pkg::result_t out_data_reg;

    assign in_item = '{kind: in_ch.kind, vert_a: in_ch.vert_a,
                       vert_b: in_ch.vert_b, vert_c: in_ch.vert_c};

    // search sequencer: owns the table size and walks the ram per edge
    uetb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // edge entries: low vertex, high vertex, use count in one word
    uetb_edge_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // a result moves in when the slot is empty or being drained this cycle
    assign res_take = res_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.edge_ab_index = out_data_reg.ab.index;
    assign out_ch.edge_ab_valid = out_data_reg.ab.valid;
    assign out_ch.edge_ab_uses  = out_data_reg.ab.uses;
    assign out_ch.edge_bc_index = out_data_reg.bc.index;
    assign out_ch.edge_bc_valid = out_data_reg.bc.valid;
    assign out_ch.edge_bc_uses  = out_data_reg.bc.uses;
    assign out_ch.edge_ca_index = out_data_reg.ca.index;
    assign out_ch.edge_ca_valid = out_data_reg.ca.valid;
    assign out_ch.edge_ca_uses  = out_data_reg.ca.uses;
    assign out_ch.edge_total    = out_data_reg.total;

    // the sequencer never takes a new item while a result waits inside it
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && res_valid))
        else $error("input taken while a result is pending");

    // a failed edge only comes from a full table or a clear item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !(out_data_reg.ab.valid && out_data_reg.bc.valid
                            && out_data_reg.ca.valid))
        |-> (out_data_reg.total == uetb_pkg::CAP_COUNT || out_data_reg.total == '0))
        else $error("edge failed while the table had room");

    // a stored edge always has a nonzero use count, a failed one none
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.ab.valid == (out_data_reg.ab.uses != '0))
                        && (out_data_reg.bc.valid == (out_data_reg.bc.uses != '0))
                        && (out_data_reg.ca.valid == (out_data_reg.ca.uses != '0))))
        else $error("use count disagrees with valid flag");

endmodule

`default_nettype wire
